>>> rtl/fdcs_pkg.sv
// fdcs_pkg: shared types, register indexes, fan curve table and pwm scaling
// for the fan duty curve slew controller
// no dependencies
`default_nettype none

package fdcs_pkg;

  localparam int unsigned TempW = 8;
  localparam int unsigned DutyW = 7;
  localparam int unsigned PwmW  = 8;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAutoEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinDuty    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRiseLimit  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRiseStep   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFallLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgFallStep   = 3'd5;

  localparam logic [DutyW-1:0] DutyMax      = 7'd100;
  localparam logic [TempW-1:0] CurveLowTemp  = 8'd56;
  localparam logic [TempW-1:0] CurveHighTemp = 8'd95;
  localparam logic [DutyW-1:0] CurveLowDuty  = 7'd30;
  localparam logic [DutyW-1:0] CurveHighDuty = 7'd100;

  typedef struct packed {
    logic [TempW-1:0] cpu_deg;
    logic [TempW-1:0] gpu_deg;
  } fdcs_in_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_percent;
    logic [PwmW-1:0]  cpu_pwm;
    logic [PwmW-1:0]  gpu_pwm;
    logic             duty_changed;
    logic [TempW-1:0] hottest_temp;
  } fdcs_out_t;

  // target duty for 56..95 degrees
  localparam logic [DutyW-1:0] FanCurve [40] = '{
    7'd30, 7'd31, 7'd31, 7'd31, 7'd32, 7'd32, 7'd32, 7'd33, 7'd33, 7'd34,
    7'd34, 7'd35, 7'd35, 7'd36, 7'd37, 7'd39, 7'd40, 7'd43, 7'd44, 7'd46,
    7'd48, 7'd52, 7'd53, 7'd55, 7'd57, 7'd60, 7'd62, 7'd65, 7'd67, 7'd70,
    7'd75, 7'd80, 7'd82, 7'd85, 7'd87, 7'd90, 7'd93, 7'd95, 7'd95, 7'd100
  };

  function automatic logic [DutyW-1:0] curve_lookup(input logic [TempW-1:0] t);
    logic [TempW-1:0] ofs;
    ofs = t - CurveLowTemp;
    if (t >= CurveHighTemp) begin
      return CurveHighDuty;
    end else if (t <= CurveLowTemp) begin
      return CurveLowDuty;
    end else begin
      return FanCurve[ofs[5:0]];
    end
  endfunction

  // (duty*255 + bias) / 100 by reciprocal multiply, exact for duty <= 100
  localparam int unsigned RecipShift = 21;
  localparam logic [14:0] Recip100   = 15'd20972;

  function automatic logic [PwmW-1:0] pwm_scale(input logic [DutyW-1:0] duty,
                                                input logic             round_up);
    logic [14:0] x;
    logic [29:0] prod;
    x    = ({8'd0, duty} << 8) - {8'd0, duty} + (round_up ? 15'd50 : 15'd0);
    prod = {15'd0, x} * {15'd0, Recip100};
    return prod[RecipShift +: PwmW];
  endfunction

endpackage

`default_nettype wire

>>> rtl/fan_duty_curve_slew_controller.sv
// fan_duty_curve_slew_controller: top level, fan curve lookup, slew limit and pwm
// depends on fdcs_pkg
//
// Each accepted beat carries one cpu/gpu temperature sample. The hotter one is
// mapped through the fixed fan curve; while auto enable is set the held duty
// moves toward that target under the rise/fall slew limits and the min_duty
// floor. One result beat (duty, truncated and rounded 8-bit pwm, change flag,
// hottest temperature) comes out of the result register on the cycle after
// acceptance. A new sample is taken every cycle unless the input stalls, which
// happens only while the single result register holds a beat the sink stalls.
// Configuration writes are always ready and take effect on the next sample.
`default_nettype none

module fan_duty_curve_slew_controller (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire fdcs_pkg::fdcs_in_t           in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output fdcs_pkg::fdcs_out_t               out_data_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [fdcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [fdcs_pkg::DutyW-1:0]   cfg_data_i
);

  logic                       auto_enable_q;
  logic [fdcs_pkg::DutyW-1:0] min_duty_q, rise_limit_q, rise_step_q;
  logic [fdcs_pkg::DutyW-1:0] fall_limit_q, fall_step_q;
  logic [fdcs_pkg::DutyW-1:0] duty_q, duty_d;
  logic                       out_valid_q;
  fdcs_pkg::fdcs_out_t        out_data_q, out_data_d;
  logic                       in_acc;
  logic                       changed;

  logic [fdcs_pkg::TempW-1:0] hot;
  logic [fdcs_pkg::DutyW-1:0] target;
  logic signed [8:0]          cur_s, tgt_s, min_s, cand_s;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_enable_q <= 1'b1;
      min_duty_q    <= 7'd20;
      rise_limit_q  <= 7'd3;
      rise_step_q   <= 7'd2;
      fall_limit_q  <= 7'd1;
      fall_step_q   <= 7'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        fdcs_pkg::CfgAutoEnable: auto_enable_q <= cfg_data_i[0];
        fdcs_pkg::CfgMinDuty:    min_duty_q    <= cfg_data_i;
        fdcs_pkg::CfgRiseLimit:  rise_limit_q  <= cfg_data_i;
        fdcs_pkg::CfgRiseStep:   rise_step_q   <= cfg_data_i;
        fdcs_pkg::CfgFallLimit:  fall_limit_q  <= cfg_data_i;
        fdcs_pkg::CfgFallStep:   fall_step_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    hot    = (in_data_i.cpu_deg > in_data_i.gpu_deg) ? in_data_i.cpu_deg
                                                     : in_data_i.gpu_deg;
    target = fdcs_pkg::curve_lookup(hot);
    cur_s  = $signed({2'b00, duty_q});
    tgt_s  = $signed({2'b00, target});
    min_s  = $signed({2'b00, min_duty_q});
    cand_s = tgt_s;
    if (tgt_s > cur_s) begin
      if ((tgt_s - cur_s) > $signed({2'b00, rise_limit_q})) begin
        cand_s = cur_s + $signed({2'b00, rise_step_q});
      end
      if (cand_s < min_s) begin
        cand_s = min_s;
      end
    end else if (tgt_s < cur_s) begin
      if ((cur_s - tgt_s) > $signed({2'b00, fall_limit_q})) begin
        cand_s = cur_s - $signed({2'b00, fall_step_q});
      end
      if (cand_s < min_s) begin
        cand_s = min_s;
      end
    end
    // keep the candidate in 0..100
    if (cand_s < 9'sd0) begin
      cand_s = 9'sd0;
    end else if (cand_s > $signed({2'b00, fdcs_pkg::DutyMax})) begin
      cand_s = $signed({2'b00, fdcs_pkg::DutyMax});
    end
    changed = auto_enable_q && (cand_s != 9'sd0) && (cand_s != cur_s);
    duty_d  = changed ? cand_s[fdcs_pkg::DutyW-1:0] : duty_q;

    out_data_d.duty_percent = duty_d;
    out_data_d.cpu_pwm      = fdcs_pkg::pwm_scale(duty_d, 1'b0);
    out_data_d.gpu_pwm      = fdcs_pkg::pwm_scale(duty_d, 1'b1);
    out_data_d.duty_changed = changed;
    out_data_d.hottest_temp = hot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        duty_q      <= duty_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded only on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fdcs_checker.sv
// fdcs_checker: port-level assertions for the fan duty curve slew controller
// depends on fdcs_pkg; bound to fan_duty_curve_slew_controller below
`default_nettype none

module fdcs_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire fdcs_pkg::fdcs_out_t out_data_o
);

  // a held result beat stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // every accepted sample shows up as a result on the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted sample produced no result");

  // input only stalls behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result register free");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty_percent <= fdcs_pkg::DutyMax)
    else $error("duty above 100");

  a_changed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.duty_changed |-> out_data_o.duty_percent != '0)
    else $error("change flagged with zero duty");

endmodule

bind fan_duty_curve_slew_controller fdcs_checker u_fdcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> dv/tb_fan_duty_curve_slew_controller.sv
// tb_fan_duty_curve_slew_controller: self-checking bench for the fan duty curve slew controller
// drives temperature samples and register writes, predicts every result beat and compares
// depends on fdcs_pkg and fan_duty_curve_slew_controller
`default_nettype none

module tb_fan_duty_curve_slew_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import fdcs_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ChunkSamples = 310;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 3'd6;

  typedef enum logic {RowSample, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CfgIdxW-1:0] idx;
    logic [DutyW-1:0]  val;
    logic [TempW-1:0]  cpu;
    logic [TempW-1:0]  gpu;
    bit                typed;
    fdcs_out_t         want;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  fdcs_in_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  fdcs_out_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DutyW-1:0]   cfg_data_i = '0;

  fan_duty_curve_slew_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // predicted controller state and register copies
  int model_duty = 0;
  int auto_on = 1;
  int min_pct = 20;
  int rise_gap = 3;
  int rise_inc = 2;
  int fall_gap = 1;
  int fall_inc = 1;

  fdcs_out_t pending_duty[$];
  int        mismatch_cnt = 0;
  int        src_idle_pct = 0;
  int        dst_idle_pct = 0;
  int        cycle_cnt = 0;

  function automatic fdcs_out_t predict_fan_step(input fdcs_in_t s);
    fdcs_out_t r;
    int hot, tgt, nxt;
    logic chg;
    hot = (s.cpu_deg > s.gpu_deg) ? int'(s.cpu_deg) : int'(s.gpu_deg);
    chg = 1'b0;
    if (auto_on != 0) begin
      if (hot >= int'(CurveHighTemp)) begin
        tgt = int'(CurveHighDuty);
      end else if (hot <= int'(CurveLowTemp)) begin
        tgt = int'(CurveLowDuty);
      end else begin
        tgt = int'(FanCurve[hot - int'(CurveLowTemp)]);
      end
      nxt = tgt;
      if (tgt > model_duty) begin
        if (tgt - model_duty > rise_gap) nxt = model_duty + rise_inc;
        if (nxt < min_pct) nxt = min_pct;
      end else if (tgt < model_duty) begin
        if (model_duty - tgt > fall_gap) nxt = model_duty - fall_inc;
        if (nxt < min_pct) nxt = min_pct;
      end
      if (nxt < 0) nxt = 0;
      if (nxt > int'(DutyMax)) nxt = int'(DutyMax);
      if (nxt != 0 && nxt != model_duty) begin
        model_duty = nxt;
        chg = 1'b1;
      end
    end
    r.duty_percent = DutyW'(model_duty);
    r.cpu_pwm      = PwmW'((model_duty * 255) / 100);
    r.gpu_pwm      = PwmW'((model_duty * 255 + 50) / 100);
    r.duty_changed = chg;
    r.hottest_temp = TempW'(hot);
    return r;
  endfunction

  // register values: extremes now and then, otherwise small steps or anything
  function automatic logic [DutyW-1:0] pick_reg(input bit is_step);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 7'd0;
    if (roll < 14) return 7'd100;
    if (roll < 20) return 7'd127;
    if (roll < 70) return is_step ? DutyW'($urandom_range(8, 1)) : DutyW'($urandom_range(40));
    return DutyW'($urandom_range(127));
  endfunction

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DutyW-1:0] val);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgAutoEnable: auto_on  = int'(val[0]);
      CfgMinDuty:    min_pct  = int'(val);
      CfgRiseLimit:  rise_gap = int'(val);
      CfgRiseStep:   rise_inc = int'(val);
      CfgFallLimit:  fall_gap = int'(val);
      CfgFallStep:   fall_inc = int'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input fdcs_in_t s, input bit typed, input fdcs_out_t want);
    fdcs_out_t p;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_fan_step(s);
    pending_duty.push_back(typed ? want : p);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= (dst_idle_pct != 0) && ($urandom_range(99) < dst_idle_pct);
  end

  always @(posedge clk_i) begin
    fdcs_out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_duty.size() == 0) begin
        $error("result beat with nothing expected: duty %0d", out_data_o.duty_percent);
        mismatch_cnt++;
      end else begin
        w = pending_duty.pop_front();
        if (out_data_o.duty_percent !== w.duty_percent) begin
          $error("duty_percent exp %0d got %0d", w.duty_percent, out_data_o.duty_percent);
          mismatch_cnt++;
        end
        if (out_data_o.cpu_pwm !== w.cpu_pwm) begin
          $error("cpu_pwm exp %0d got %0d", w.cpu_pwm, out_data_o.cpu_pwm);
          mismatch_cnt++;
        end
        if (out_data_o.gpu_pwm !== w.gpu_pwm) begin
          $error("gpu_pwm exp %0d got %0d", w.gpu_pwm, out_data_o.gpu_pwm);
          mismatch_cnt++;
        end
        if (out_data_o.duty_changed !== w.duty_changed) begin
          $error("duty_changed exp %0d got %0d", w.duty_changed, out_data_o.duty_changed);
          mismatch_cnt++;
        end
        if (out_data_o.hottest_temp !== w.hottest_temp) begin
          $error("hottest_temp exp %0d got %0d", w.hottest_temp, out_data_o.hottest_temp);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // directed sequence starting from the reset register values
  plan_row_t plan[$] = '{
    '{RowSample, CfgAutoEnable, 7'd0, 8'd0, 8'd0, 1'b1, '{7'd20, 8'd51, 8'd51, 1'b1, 8'd0}},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd255, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd0, 8'd255, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'hAA, 8'h55, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'h55, 8'hAA, 1'b0, '0},
    // wide rise limit: jump straight to the hot end of the curve
    '{RowCfg, CfgRiseLimit, 7'd100, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd95, 8'd94, 1'b1, '{7'd100, 8'd255, 8'd255, 1'b1, 8'd95}},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd100, 8'd100, 1'b1, '{7'd100, 8'd255, 8'd255, 1'b0, 8'd100}},
    // big fall step lands on the floor
    '{RowCfg, CfgFallLimit, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgFallStep, 7'd100, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd56, 8'd56, 1'b1, '{7'd20, 8'd51, 8'd51, 1'b1, 8'd56}},
    '{RowCfg, CfgMinDuty, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd57, 8'd0, 1'b0, '0},
    // step below zero with no floor clamps to zero and is not applied
    '{RowCfg, CfgFallStep, 7'd127, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd0, 8'd0, 1'b1, '{7'd31, 8'd79, 8'd79, 1'b0, 8'd0}},
    // floor above full scale clamps to 100
    '{RowCfg, CfgMinDuty, 7'd127, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd94, 8'd0, 1'b1, '{7'd100, 8'd255, 8'd255, 1'b1, 8'd94}},
    // only bit 0 of the enable counts
    '{RowCfg, CfgAutoEnable, 7'd2, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd0, 8'd0, 1'b1, '{7'd100, 8'd255, 8'd255, 1'b0, 8'd0}},
    '{RowCfg, CfgAutoEnable, 7'd1, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgMinDuty, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgRiseLimit, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgFallStep, 7'd1, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    // zero rise step holds the duty
    '{RowCfg, CfgRiseStep, 7'd0, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd95, 8'd95, 1'b1, '{7'd99, 8'd252, 8'd252, 1'b0, 8'd95}},
    '{RowCfg, CfgRiseStep, 7'd127, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd60, 8'd60, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd255, 8'd255, 1'b1, '{7'd100, 8'd255, 8'd255, 1'b1, 8'd255}},
    '{RowCfg, CfgSpareIdx, 7'h7F, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgAutoEnable, 7'd1, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgMinDuty, 7'd20, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgRiseLimit, 7'd3, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgRiseStep, 7'd2, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgFallLimit, 7'd1, 8'd0, 8'd0, 1'b0, '0},
    '{RowCfg, CfgFallStep, 7'd1, 8'd0, 8'd0, 1'b0, '0},
    '{RowSample, CfgAutoEnable, 7'd0, 8'd0, 8'd0, 1'b0, '0}
  };

  initial begin
    fdcs_in_t         s;
    logic [DutyW-1:0] en_val;
    int               walk_temp;
    int               spread;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 28;
    dst_idle_pct = 64;
    foreach (plan[i]) begin
      if (plan[i].kind == RowCfg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        s.cpu_deg = plan[i].cpu;
        s.gpu_deg = plan[i].gpu;
        send_sample(s, plan[i].typed, plan[i].want);
      end
    end

    walk_temp = 70;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 64 : 0;
      dst_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 28 : 0;
      for (int chunk = 0; chunk < 2; chunk++) begin
        en_val = DutyW'($urandom_range(127));
        en_val[0] = ($urandom_range(99) < 85);
        write_reg(CfgAutoEnable, en_val);
        write_reg(CfgMinDuty, pick_reg(1'b0));
        write_reg(CfgRiseLimit, pick_reg(1'b0));
        write_reg(CfgRiseStep, pick_reg(1'b1));
        write_reg(CfgFallLimit, pick_reg(1'b0));
        write_reg(CfgFallStep, pick_reg(1'b1));
        for (int n = 0; n < ChunkSamples; n++) begin
          // temperatures mostly drift across the curve, sometimes jump anywhere
          walk_temp += $urandom_range(12) - 6;
          if (walk_temp < 40) walk_temp = 40;
          if (walk_temp > 110) walk_temp = 110;
          spread = $urandom_range(10);
          s.cpu_deg = TempW'(walk_temp + spread);
          s.gpu_deg = TempW'(walk_temp - spread);
          if ($urandom_range(99) < 20) s.cpu_deg = TempW'($urandom_range(255));
          if ($urandom_range(99) < 20) s.gpu_deg = TempW'($urandom_range(255));
          send_sample(s, 1'b0, '0);
        end
      end
    end

    settle();
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_duty.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/fdcs_pkg.sv
rtl/fan_duty_curve_slew_controller.sv
rtl/fdcs_checker.sv
dv/tb_fan_duty_curve_slew_controller.sv
